>>> hw/rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants of the pairwise point distance unit.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int MAX_POINTS    = 8;
  localparam int FRACTION_BITS = 8;

  localparam int COORD_W  = 16;
  localparam int IDX_W    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int ABS_W    = COORD_W;
  localparam int SUM_W    = 2 * COORD_W + 2;
  localparam int ROOT_W   = SUM_W / 2 + FRACTION_BITS;
  localparam int OIDX_W   = 3;
  localparam int DIST_W   = 25;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DIST = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_DIST  = 2'd2,
    ST_FEW   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_WAIT
  } state_e;

endpackage

>>> hw/rtl/ppd_sqrt.sv
// ----------------------------------------------------------------------------
// ppd_sqrt
// Iterative fixed-point square root: one result bit per cycle.
// ----------------------------------------------------------------------------
module ppd_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppd_pkg::SUM_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [ppd_pkg::ROOT_W-1:0] root_o
);
  import ppd_pkg::*;

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;
  logic              done_q, done_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // The radicand is scaled by the fraction bits so that the root carries them.
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = {radicand_i, (2 * FRACTION_BITS)'(0)};
      rem_d  = '0;
      root_d = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(ROOT_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/pairwise_point_distance_unit.sv
// ----------------------------------------------------------------------------
// pairwise_point_distance_unit
// Point store with Euclidean distances over all stored pairs.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// command   in         start && !busy           operation_i, x_coord_i, y_coord_i
// result    out        result_valid_o (1 cycle) status_o, first_index_o,
//                                               second_index_o, distance_o, last_o
//
// An add gives its result in the cycle after it is taken; busy stays low.
// A compute handles one stored pair at a time: read, difference, two passes
// through the shared 16x16 multiplier, then the bit-serial square root,
// which dominates. A compute with fewer than two points answers in the next
// cycle. Reset empties the store at once.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module pairwise_point_distance_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  y_coord_i,
  output logic                                result_valid_o,
  output logic [ppd_pkg::STATUS_W-1:0]        status_o,
  output logic [ppd_pkg::OIDX_W-1:0]          first_index_o,
  output logic [ppd_pkg::OIDX_W-1:0]          second_index_o,
  output logic [ppd_pkg::DIST_W-1:0]          distance_o,
  output logic                                last_o
);
  import ppd_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     i_q, i_d, j_q, j_d;
  logic [SUM_W-1:0]     acc_q, acc_d;
  logic [2*COORD_W-1:0] mem_q [MAX_POINTS];
  logic [2*COORD_W-1:0] pt_i_q, pt_j_q;
  logic [ABS_W-1:0]     ax_q, ay_q;
  logic                 wr_en;

  logic                 res_valid_q, res_valid_d;
  status_e              status_q, status_d;
  logic [OIDX_W-1:0]    fidx_q, fidx_d, sidx_q, sidx_d;
  logic [DIST_W-1:0]    dist_q, dist_d;
  logic                 last_q, last_d;

  logic                 sq_start;
  logic                 sq_done;
  logic [ROOT_W-1:0]    sq_root;

  logic [ABS_W-1:0]     mul_op;
  logic [2*ABS_W-1:0]   prod;
  logic signed [COORD_W:0] dx, dy;
  logic                 j_end, pair_last;

  // Differences are one bit wider so that the magnitude never overflows.
  assign dx = {pt_j_q[2*COORD_W-1], pt_j_q[2*COORD_W-1 -: COORD_W]}
            - {pt_i_q[2*COORD_W-1], pt_i_q[2*COORD_W-1 -: COORD_W]};
  assign dy = {pt_j_q[COORD_W-1], pt_j_q[COORD_W-1:0]}
            - {pt_i_q[COORD_W-1], pt_i_q[COORD_W-1:0]};

  assign mul_op = (state_q == S_SQX) ? ax_q : ay_q;
  assign prod   = mul_op * mul_op;

  assign j_end     = (CNT_W'(j_q) == count_q - CNT_W'(1));
  assign pair_last = j_end && (CNT_W'(i_q) == count_q - CNT_W'(2));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    acc_d       = acc_q;
    wr_en       = 1'b0;
    sq_start    = 1'b0;
    res_valid_d = 1'b0;
    status_d    = status_q;
    fidx_d      = fidx_q;
    sidx_d      = sidx_q;
    dist_d      = dist_q;
    last_d      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_valid_d = 1'b1;
          fidx_d      = '0;
          sidx_d      = '0;
          dist_d      = '0;
          last_d      = 1'b1;
          if (operation_i == OP_ADD) begin
            if (count_q == CNT_W'(MAX_POINTS)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_ADDED;
              fidx_d   = OIDX_W'(count_q);
              wr_en    = 1'b1;
              count_d  = count_q + CNT_W'(1);
            end
          end else if (count_q < CNT_W'(2)) begin
            status_d = ST_FEW;
          end else begin
            res_valid_d = 1'b0;
            i_d         = '0;
            j_d         = IDX_W'(1);
            state_d     = S_READ;
          end
        end
      end
      S_READ: state_d = S_DIFF;
      S_DIFF: state_d = S_SQX;
      S_SQX: begin
        acc_d   = SUM_W'(prod);
        state_d = S_SQY;
      end
      S_SQY: begin
        acc_d   = acc_q + SUM_W'(prod);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        sq_start = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (sq_done) begin
          res_valid_d = 1'b1;
          status_d    = ST_DIST;
          fidx_d      = OIDX_W'(i_q);
          sidx_d      = OIDX_W'(j_q);
          dist_d      = DIST_W'(sq_root);
          last_d      = pair_last;
          if (pair_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_READ;
            if (j_end) begin
              i_d = i_q + IDX_W'(1);
              j_d = i_q + IDX_W'(2);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    acc_q    <= acc_d;
    status_q <= status_d;
    fidx_q   <= fidx_d;
    sidx_q   <= sidx_d;
    dist_q   <= dist_d;
    last_q   <= last_d;
  end

  // Point store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IDX_W-1:0]] <= {x_coord_i, y_coord_i};
    end
    if (state_q == S_READ) begin
      pt_i_q <= mem_q[i_q];
      pt_j_q <= mem_q[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIFF) begin
      ax_q <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
      ay_q <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    end
  end

  ppd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (acc_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign first_index_o  = fidx_q;
  assign second_index_o = sidx_q;
  assign distance_o     = dist_q;
  assign last_o         = last_q;

endmodule

>>> hw/rtl/ppd_checker.sv
// ----------------------------------------------------------------------------
// ppd_checker
// Port-level checks of the pairwise point distance unit.
// ----------------------------------------------------------------------------
module ppd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                operation_i,
  input logic                                result_valid_o,
  input logic [ppd_pkg::STATUS_W-1:0]        status_o,
  input logic [ppd_pkg::OIDX_W-1:0]          second_index_o,
  input logic [ppd_pkg::DIST_W-1:0]          distance_o,
  input logic                                last_o
);
  import ppd_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // An add always answers with exactly one final item in the next cycle.
  a_add_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i == OP_ADD) |=> result_valid_o && last_o
      && (status_o == ST_ADDED || status_o == ST_FULL))
    else $error("add item not answered in the next cycle");

  // A compute either starts the pair walk or reports too few points.
  a_dist_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i == OP_DIST) |=> busy
      || (result_valid_o && last_o && status_o == ST_FEW))
    else $error("compute item neither started nor rejected");

  // Only distance items can be followed by more items of the same command.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_DIST) |-> last_o)
    else $error("non-distance item without last");

  // While more pairs are pending the unit must stay busy.
  a_busy_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("intermediate item while not busy");

  // Status items carry no pair and no distance.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_DIST) |-> (second_index_o == '0)
      && (distance_o == '0))
    else $error("status item with pair fields set");

endmodule

bind pairwise_point_distance_unit ppd_checker u_ppd_checker (.*);
